@@ sv/cwc_pkg.sv @@
// Shared constants for the four-way cache directory: defaults, config indexes, policy codes.
`default_nettype none
package cwc_pkg;

  localparam int DEF_WAYS      = 4;
  localparam int DEF_MAX_SETS  = 128;
  localparam int DEF_ADDR_BITS = 32;

  localparam int IN_ADDR_W = 32;
  localparam int OUT_WAY_W = 2;
  localparam int COUNT_W   = 32;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_LOG2  = 2'd2;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  localparam logic [2:0] RST_LINE_LOG2 = 3'd4;
  localparam logic [2:0] RST_SET_LOG2  = 3'd3;

  // set index is masked to at most 7 bits before the wrap
  localparam int SET_RAW_W = 7;

endpackage
`default_nettype wire

@@ sv/cwc_tag_ram.sv @@
// Set memory: one row per set holding valid, age and tag of every way, with a clearing sweep.
`default_nettype none
module cwc_tag_ram #(
  parameter int MAX_SETS = cwc_pkg::DEF_MAX_SETS,
  parameter int ROW_W    = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         rd_en,
  input  wire [$clog2(MAX_SETS)-1:0]  rd_set,
  output logic [ROW_W-1:0]            rd_row,
  input  wire                         wr_en,
  input  wire [$clog2(MAX_SETS)-1:0]  wr_set,
  input  wire [ROW_W-1:0]             wr_row,
  output logic                        clr_busy
);

  localparam int SET_W = $clog2(MAX_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  logic [ROW_W-1:0] mem [MAX_SETS];
  logic [ROW_W-1:0] rd_row_r;
  logic [SET_W-1:0] clr_cnt_r;
  logic             clearing_r;

  logic             we;
  logic [SET_W-1:0] wa;
  logic [ROW_W-1:0] wd;

  always_comb begin
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_set;
      wd = wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == LAST_SET) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_set];
    end
  end

  assign rd_row   = rd_row_r;
  assign clr_busy = clearing_r;

endmodule
`default_nettype wire

@@ sv/cwc_way_pick.sv @@
// Tag compare, fill or victim choice, and age update of one set row.
`default_nettype none
module cwc_way_pick #(
  parameter int WAYS  = cwc_pkg::DEF_WAYS,
  parameter int AW    = 32,
  parameter int AGE_W = 2,
  parameter int ROW_W = 8
) (
  input  wire [ROW_W-1:0]          row_i,
  input  wire [AW-1:0]             line_i,
  input  wire                      policy_i,
  output logic                     hit_o,
  output logic [$clog2(WAYS)-1:0]  way_o,
  output logic [ROW_W-1:0]         row_o
);

  localparam int WAY_W  = $clog2(WAYS);
  localparam int AGE_LO = WAYS * AW;
  localparam int VLD_LO = AGE_LO + WAYS * AGE_W;

  logic [AW-1:0]    tag_a   [WAYS];
  logic [AGE_W-1:0] age_a   [WAYS];
  logic             vld_a   [WAYS];
  logic [AW-1:0]    tag_n   [WAYS];
  logic [AGE_W-1:0] age_n   [WAYS];
  logic             vld_n   [WAYS];

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             empty_f;
  logic [WAY_W-1:0] empty_way;
  logic [AGE_W-1:0] oldest;
  logic [WAY_W-1:0] old_way;
  logic [WAY_W-1:0] tw;
  logic             upd;
  logic             was_v;
  logic [AGE_W-1:0] old_a;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty_f   = 1'b0;
    empty_way = '0;
    oldest    = '0;
    old_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      tag_a[w] = row_i[w*AW +: AW];
      age_a[w] = row_i[AGE_LO + w*AGE_W +: AGE_W];
      vld_a[w] = row_i[VLD_LO + w];
    end
    // first matching way, first empty way, lowest way with greatest age
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vld_a[w] && tag_a[w] == line_i) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!empty_f && !vld_a[w]) begin
        empty_f   = 1'b1;
        empty_way = WAY_W'(w);
      end
      if (age_a[w] > oldest) begin
        oldest  = age_a[w];
        old_way = WAY_W'(w);
      end
    end

    tw    = hit ? hit_way : (empty_f ? empty_way : old_way);
    upd   = !hit || (policy_i == cwc_pkg::POLICY_LRU);
    was_v = vld_a[tw];
    old_a = age_a[tw];

    for (int j = 0; j < WAYS; j++) begin
      tag_n[j] = tag_a[j];
      vld_n[j] = vld_a[j];
      age_n[j] = age_a[j];
      if (upd && WAY_W'(j) != tw && vld_a[j] && (!was_v || age_a[j] < old_a) &&
          age_a[j] != '1) begin
        age_n[j] = AGE_W'(age_a[j] + 1'b1);
      end
    end
    if (upd) begin
      age_n[tw] = '0;
    end
    if (!hit) begin
      tag_n[tw] = line_i;
      vld_n[tw] = 1'b1;
    end

    for (int w = 0; w < WAYS; w++) begin
      row_o[w*AW +: AW]                = tag_n[w];
      row_o[AGE_LO + w*AGE_W +: AGE_W] = age_n[w];
      row_o[VLD_LO + w]                = vld_n[w];
    end
  end

  assign hit_o = hit;
  assign way_o = tw;

endmodule
`default_nettype wire

@@ sv/four_way_cache_hit_and_replace_top.sv @@
// Top level of the set-associative cache directory with LRU or FIFO replacement.
//
//   channel  ports                                   handshake
//   in       start, busy, in_address                 taken when start && !busy
//   out      out_valid, out_hit, out_way,            one-cycle strobe, no stall
//            out_hit_count
//   cfg      cfg_we, cfg_idx, cfg_wdata              write when cfg_we
//
// The set row of each word is read from the set memory on the accept edge, then
// compared and updated in ST_LOOK and written back as the result strobe is registered.
// busy is high in ST_LOOK. After reset a clearing sweep over all MAX_SETS sets
// holds busy high. The receiver cannot stall the result.
`default_nettype none
module four_way_cache_hit_and_replace_top #(
  parameter int WAYS      = cwc_pkg::DEF_WAYS,
  parameter int MAX_SETS  = cwc_pkg::DEF_MAX_SETS,
  parameter int ADDR_BITS = cwc_pkg::DEF_ADDR_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [cwc_pkg::IN_ADDR_W-1:0]     in_address,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [cwc_pkg::OUT_WAY_W-1:0]    out_way,
  output logic [cwc_pkg::COUNT_W-1:0]      out_hit_count,
  input  wire                              cfg_we,
  input  wire [cwc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [cwc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW     = (ADDR_BITS < cwc_pkg::IN_ADDR_W) ? ADDR_BITS : cwc_pkg::IN_ADDR_W;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int AGE_W  = (WAYS > 2) ? $clog2(WAYS) : 1;
  localparam int SET_W  = $clog2(MAX_SETS);
  localparam int ROW_W  = WAYS * (1 + AGE_W + AW);
  localparam int RAW_W  = cwc_pkg::SET_RAW_W;
  localparam int RAW_N  = 1 << RAW_W;

  typedef enum logic {ST_IDLE, ST_LOOK} state_t;

  state_t                     state_r;
  logic                       policy_r;
  logic [2:0]                 line_log2_r;
  logic [2:0]                 set_log2_r;
  logic [AW-1:0]              line_r;
  logic [SET_W-1:0]           set_r;
  logic [cwc_pkg::COUNT_W-1:0] hit_count_r;
  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [cwc_pkg::OUT_WAY_W-1:0] out_way_r;

  logic                       clr_busy;
  logic                       accept;
  logic [AW-1:0]              line;
  logic [RAW_W:0]             set_mask;
  logic [RAW_W-1:0]           set_raw;
  logic [SET_W-1:0]           set_tbl [RAW_N];
  logic [SET_W-1:0]           set_idx;
  logic [ROW_W-1:0]           rd_row;
  logic [ROW_W-1:0]           new_row;
  logic                       pick_hit;
  logic [WAY_W-1:0]           pick_way;

  // set index wraps modulo MAX_SETS
  for (genvar i = 0; i < RAW_N; i++) begin : g_wrap
    assign set_tbl[i] = SET_W'(i % MAX_SETS);
  end

  assign busy     = clr_busy || (state_r == ST_LOOK);
  assign accept   = start && !busy;
  assign line     = in_address[AW-1:0] >> line_log2_r;
  assign set_mask = (RAW_W+1)'((RAW_W+1)'(1) << set_log2_r) - 1'b1;
  assign set_raw  = line[RAW_W-1:0] & set_mask[RAW_W-1:0];
  assign set_idx  = set_tbl[set_raw];

  cwc_tag_ram #(
    .MAX_SETS (MAX_SETS),
    .ROW_W    (ROW_W)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_set   (set_idx),
    .rd_row   (rd_row),
    .wr_en    (state_r == ST_LOOK),
    .wr_set   (set_r),
    .wr_row   (new_row),
    .clr_busy (clr_busy)
  );

  cwc_way_pick #(
    .WAYS  (WAYS),
    .AW    (AW),
    .AGE_W (AGE_W),
    .ROW_W (ROW_W)
  ) u_pick (
    .row_i    (rd_row),
    .line_i   (line_r),
    .policy_i (policy_r),
    .hit_o    (pick_hit),
    .way_o    (pick_way),
    .row_o    (new_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= cwc_pkg::POLICY_LRU;
      line_log2_r <= cwc_pkg::RST_LINE_LOG2;
      set_log2_r  <= cwc_pkg::RST_SET_LOG2;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cwc_pkg::CFG_POLICY:    policy_r    <= cfg_wdata[0];
        cwc_pkg::CFG_LINE_LOG2: line_log2_r <= cfg_wdata;
        cwc_pkg::CFG_SET_LOG2:  set_log2_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r <= line;
      set_r  <= set_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_way_r   <= '0;
      hit_count_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          out_hit_r   <= pick_hit;
          out_way_r   <= cwc_pkg::OUT_WAY_W'(pick_way);
          if (pick_hit && hit_count_r != '1) begin
            hit_count_r <= hit_count_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_way       = out_way_r;
  assign out_hit_count = hit_count_r;

endmodule
`default_nettype wire

@@ bench/four_way_cache_hit_and_replace_top_tb.sv @@
// Testbench for the four-way cache directory: directed and random lookups checked against a predictor.
`timescale 1ns / 100ps
module four_way_cache_hit_and_replace_top_tb;

  localparam int NSETS = cwc_pkg::DEF_MAX_SETS;
  localparam int NWAYS = cwc_pkg::DEF_WAYS;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [cwc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic                          hit;
    logic [cwc_pkg::OUT_WAY_W-1:0] way;
    logic [cwc_pkg::COUNT_W-1:0]   hits;
  } lookup_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [cwc_pkg::IN_ADDR_W-1:0] in_address = '0;
  logic cfg_we = 1'b0;
  logic [cwc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [cwc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic busy, out_valid, out_hit;
  logic [cwc_pkg::OUT_WAY_W-1:0] out_way;
  logic [cwc_pkg::COUNT_W-1:0] out_hit_count;

  four_way_cache_hit_and_replace_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_address(in_address),
    .out_valid(out_valid), .out_hit(out_hit), .out_way(out_way),
    .out_hit_count(out_hit_count),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [31:0] dir_tag [NSETS][NWAYS];
  bit          dir_valid [NSETS][NWAYS];
  logic [7:0]  dir_age [NSETS][NWAYS];
  logic [31:0] hits_total;
  logic        policy_m;
  logic [2:0]  line_log2_m;
  logic [2:0]  set_log2_m;

  lookup_result_t pending_results[$];
  lookup_result_t head_result;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;

  logic [31:0] hot_lines [16];
  int hot_n;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // way w becomes youngest; other valid ways younger than it, or all if w was invalid, age by one
  function automatic void promote_way(input int s, input int w);
    bit was_valid;
    logic [7:0] old_age;
    was_valid = dir_valid[s][w];
    old_age = dir_age[s][w];
    for (int j = 0; j < NWAYS; j++) begin
      if (j != w && dir_valid[s][j] && (!was_valid || dir_age[s][j] < old_age)) begin
        if (dir_age[s][j] != 8'hFF) dir_age[s][j]++;
      end
    end
    dir_age[s][w] = 8'd0;
  endfunction

  function automatic lookup_result_t lookup_predict(input logic [31:0] addr);
    logic [31:0] line;
    int set_i;
    int way_i;
    bit hit, found;
    logic [7:0] oldest;
    lookup_result_t r;
    line = addr >> line_log2_m;
    set_i = int'((line & ((32'd1 << set_log2_m) - 32'd1)) % NSETS);
    hit = 0;
    found = 0;
    way_i = 0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!hit && dir_valid[set_i][w] && dir_tag[set_i][w] == line) begin
        hit = 1;
        way_i = w;
      end
    end
    if (hit) begin
      if (hits_total != 32'hFFFF_FFFF) hits_total++;
      if (policy_m == cwc_pkg::POLICY_LRU) promote_way(set_i, way_i);
    end else begin
      for (int w = 0; w < NWAYS; w++) begin
        if (!found && !dir_valid[set_i][w]) begin
          way_i = w;
          found = 1;
        end
      end
      if (!found) begin
        oldest = 8'd0;
        way_i = 0;
        for (int w = 0; w < NWAYS; w++) begin
          if (dir_age[set_i][w] > oldest) begin
            oldest = dir_age[set_i][w];
            way_i = w;
          end
        end
      end
      promote_way(set_i, way_i);
      dir_tag[set_i][way_i] = line;
      dir_valid[set_i][way_i] = 1;
    end
    r.hit = hit;
    r.way = way_i[cwc_pkg::OUT_WAY_W-1:0];
    r.hits = hits_total;
    return r;
  endfunction

  task automatic send_word(input logic [31:0] a);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_address <= a;
    do @(posedge clk); while (busy);
    pending_results.push_back(lookup_predict(a));
  endtask

  // stop sending and wait until every word is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(input logic [cwc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [cwc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cwc_pkg::CFG_POLICY:    policy_m = val[0];
      cwc_pkg::CFG_LINE_LOG2: line_log2_m = val;
      cwc_pkg::CFG_SET_LOG2:  set_log2_m = val;
      default: ;
    endcase
  endtask

  // reset defaults: empty set, address zero must miss, then fill and evict set 0
  task automatic test_fill_and_evict();
    idle_pct = 0;
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(32'h0000_000F);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0080);
    send_word(32'h0000_0100);
    send_word(32'h0000_0180);
    send_word(32'h0000_0000);
    send_word(32'h0000_0200);
    send_word(32'h0000_0080);
  endtask

  // FIFO under a new split; old entries are looked up under it
  task automatic test_fifo_new_split();
    drain();
    set_reg(cwc_pkg::CFG_POLICY, {2'b00, cwc_pkg::POLICY_FIFO});
    set_reg(cwc_pkg::CFG_LINE_LOG2, 3'd5);
    set_reg(cwc_pkg::CFG_SET_LOG2, 3'd1);
    send_word(32'h0000_0000);
    send_word(32'h0000_0040);
    send_word(32'h0000_00C0);
    send_word(32'h0000_0140);
    send_word(32'h0000_0000);
    send_word(32'h0000_01C0);
    send_word(32'h0000_0000);
  endtask

  task automatic test_unused_index();
    drain();
    set_reg(CFG_IDX_UNUSED, 3'd7);
    send_word(32'h0000_0020);
    send_word(32'h0000_0020);
    send_word(32'hFFFF_FFC0);
  endtask

  // register values outside the intended range
  task automatic test_odd_split();
    drain();
    set_reg(cwc_pkg::CFG_LINE_LOG2, 3'd7);
    set_reg(cwc_pkg::CFG_SET_LOG2, 3'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0000_0080);
    drain();
    set_reg(cwc_pkg::CFG_LINE_LOG2, 3'd0);
    set_reg(cwc_pkg::CFG_SET_LOG2, 3'd7);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_007F);
    send_word(32'h0000_00FF);
  endtask

  function automatic logic [31:0] fresh_line(input int set_sel);
    logic [31:0] set_bits;
    set_bits = (set_sel & ((32'd1 << set_log2_m) - 32'd1)) << line_log2_m;
    return ($urandom() << (int'(line_log2_m) + int'(set_log2_m))) | set_bits;
  endfunction

  task automatic run_phase(input logic pol, input logic [2:0] lw, input logic [2:0] sc,
                           input int pct, input int n);
    int nsets, r;
    logic [31:0] a;
    drain();
    set_reg(cwc_pkg::CFG_POLICY, {2'b00, pol});
    set_reg(cwc_pkg::CFG_LINE_LOG2, lw);
    set_reg(cwc_pkg::CFG_SET_LOG2, sc);
    idle_pct = pct;
    // a few hot lines crowded into one to three sets, so fills evict
    hot_n = $urandom_range(6, 14);
    nsets = $urandom_range(1, 3);
    for (int i = 0; i < hot_n; i++) hot_lines[i] = fresh_line(i % nsets);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        a = $urandom();
      end else begin
        if (r < 20) hot_lines[$urandom_range(0, hot_n - 1)] = fresh_line($urandom_range(0, 3));
        a = hot_lines[$urandom_range(0, hot_n - 1)] |
            ($urandom() & ((32'd1 << line_log2_m) - 32'd1));
      end
      send_word(a);
    end
  endtask

  task automatic test_random_phases();
    run_phase(cwc_pkg::POLICY_LRU,  3'd4, 3'd3, 0,  80);
    run_phase(cwc_pkg::POLICY_FIFO, 3'd5, 3'd1, 46, 80);
    run_phase(cwc_pkg::POLICY_LRU,  3'd5, 3'd7, 27, 80);
    run_phase(cwc_pkg::POLICY_FIFO, 3'd4, 3'd7, 0,  80);
    run_phase(cwc_pkg::POLICY_LRU,  3'd7, 3'd0, 46, 70);
    run_phase(cwc_pkg::POLICY_FIFO, 3'd0, 3'd2, 27, 70);
    run_phase(cwc_pkg::POLICY_LRU,  3'd1, 3'd6, 0,  70);
    run_phase(cwc_pkg::POLICY_FIFO, 3'd6, 3'd5, 46, 70);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: hit=%0b way=%0d count=%0d",
                   out_hit, out_way, out_hit_count);
      end else begin
        head_result = pending_results.pop_front();
        if (out_hit !== head_result.hit || out_way !== head_result.way ||
            out_hit_count !== head_result.hits) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b way=%0d count=%0d, got hit=%0b way=%0d count=%0d",
                     head_result.hit, head_result.way, head_result.hits,
                     out_hit, out_way, out_hit_count);
        end
      end
    end
  end

  // cycles with neither a word taken nor a word returned
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[four_way_cache_hit_and_replace_top] ERROR");
    $finish;
  end

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        dir_tag[s][w] = '0;
        dir_valid[s][w] = 0;
        dir_age[s][w] = '0;
      end
    end
    hits_total = '0;
    policy_m = cwc_pkg::POLICY_LRU;
    line_log2_m = cwc_pkg::RST_LINE_LOG2;
    set_log2_m = cwc_pkg::RST_SET_LOG2;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_fill_and_evict();
    test_fifo_new_split();
    test_unused_index();
    test_odd_split();
    test_random_phases();

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[four_way_cache_hit_and_replace_top] OK");
    end else begin
      $display("[four_way_cache_hit_and_replace_top] ERROR");
    end
    $finish;
  end

endmodule
